FILE: rtl/smhc_pkg.sv
`default_nettype none
package smhc_pkg;

    localparam int CFG_W    = 5;
    localparam int CFG_IDXW = 1;
    localparam int DIM_MAX  = 16;

    localparam logic [CFG_IDXW-1:0] CFG_ROWS = 1'd0;
    localparam logic [CFG_IDXW-1:0] CFG_COLS = 1'd1;

    localparam logic [2:0] REQ_ALL     = 3'd0;
    localparam logic [2:0] REQ_ONE     = 3'd1;
    localparam logic [2:0] REQ_ROW     = 3'd2;
    localparam logic [2:0] REQ_ROW_MEM = 3'd3;
    localparam logic [2:0] REQ_COL     = 3'd4;
    localparam logic [2:0] REQ_COL_MEM = 3'd5;
    localparam logic [2:0] REQ_MASK    = 3'd6;
    localparam logic [2:0] REQ_READ    = 3'd7;

    localparam logic [1:0] SCOPE_ALL = 2'd0;
    localparam logic [1:0] SCOPE_ROW = 2'd1;
    localparam logic [1:0] SCOPE_COL = 2'd2;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_REFUSED = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;

    localparam logic [2:0] KIND_CMD_PLAIN = 3'd0;
    localparam logic [2:0] KIND_CMD_GRID  = 3'd1;
    localparam logic [2:0] KIND_CMD_MASK  = 3'd2;
    localparam logic [2:0] KIND_RD_ALL    = 3'd3;
    localparam logic [2:0] KIND_RD_LINE   = 3'd4;
    localparam logic [2:0] KIND_RD_BAD    = 3'd5;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [2:0]  opcode;
        logic [7:0]  switch_index;
        logic [15:0] line_mask;
        logic [63:0] member_mask;
        logic [1:0]  read_scope;
        logic [3:0]  line_index;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status_code;
        logic [63:0] on_bits;
        logic [63:0] hold_bits;
        logic [6:0]  bit_total;
    } t_out_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  op;
        logic        is_col;
        logic        use_member;
        logic [15:0] line_mask;
        logic [63:0] member_mask;
        logic [8:0]  start;
        logic [4:0]  step;
        logic [8:0]  limit;
        logic [4:0]  rows;
    } t_job;

endpackage
`default_nettype wire

FILE: rtl/switch_matrix_hold_control.sv
// Channel   Direction  Handshake                 Payload
// in        input      i_in_valid / o_in_ready   i_in_data  (t_in_item)
// out       output     o_out_valid / i_out_ready o_out_data (t_out_item)
// cfg       input      i_cfg_we                  i_cfg_index, i_cfg_data
//
// An accepted command enters a two-entry job queue and is carried out by a switch walker
// that visits one matrix position per cycle, save when a stalled output holds its last step:
// SWITCH_COUNT positions for all switches, one for a single switch, rows*columns for row or
// column commands, 64 for a switch mask, the line length for a line read and one for a full or invalid read.
// Reset clears all on and hold bits and sets both dimensions to 8.
// A stalled output transfer holds the walker on its last step while the queue keeps filling.
`default_nettype none
module switch_matrix_hold_control #(
    parameter int SWITCH_COUNT = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire smhc_pkg::t_in_item            i_in_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output smhc_pkg::t_out_item                o_out_data,
    input  wire logic                          i_cfg_we,
    input  wire logic [smhc_pkg::CFG_IDXW-1:0] i_cfg_index,
    input  wire logic [smhc_pkg::CFG_W-1:0]    i_cfg_data
);
    import smhc_pkg::*;

    t_job front_job;
    t_job queue_job;
    logic queue_full;
    logic queue_valid;
    logic queue_pop;

    assign o_in_ready = !queue_full;

    smhc_front #(
        .SWITCH_COUNT(SWITCH_COUNT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_in_data),
        .o_job      (front_job)
    );

    smhc_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (i_in_valid && !queue_full),
        .i_job  (front_job),
        .o_full (queue_full),
        .i_pop  (queue_pop),
        .o_valid(queue_valid),
        .o_job  (queue_job)
    );

    smhc_back #(
        .SWITCH_COUNT(SWITCH_COUNT)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job_valid(queue_valid),
        .i_job      (queue_job),
        .o_pop      (queue_pop),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

endmodule
`default_nettype wire

FILE: rtl/smhc_front.sv
`default_nettype none
module smhc_front #(
    parameter int SWITCH_COUNT = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [smhc_pkg::CFG_IDXW-1:0] i_cfg_index,
    input  wire logic [smhc_pkg::CFG_W-1:0]    i_cfg_data,
    input  wire smhc_pkg::t_in_item            i_item,
    output smhc_pkg::t_job                     o_job
);
    import smhc_pkg::*;

    logic [CFG_W-1:0] r_rows;
    logic [CFG_W-1:0] r_cols;
    logic [CFG_W-1:0] eff_r;
    logic [CFG_W-1:0] eff_c;
    logic [8:0]       grid_size;
    logic [8:0]       col_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= CFG_W'(8);
            r_cols <= CFG_W'(8);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ROWS: r_rows <= i_cfg_data;
                CFG_COLS: r_cols <= i_cfg_data;
                default:  ;
            endcase
        end
    end

    always_comb begin
        eff_r = (r_rows == '0) ? CFG_W'(1) : (r_rows > CFG_W'(DIM_MAX)) ? CFG_W'(DIM_MAX) : r_rows;
        eff_c = (r_cols == '0) ? CFG_W'(1) : (r_cols > CFG_W'(DIM_MAX)) ? CFG_W'(DIM_MAX) : r_cols;
        grid_size = 9'(eff_r) * 9'(eff_c);
        col_base  = 9'({5'd0, i_item.line_index} * {4'd0, eff_r});
    end

    always_comb begin
        o_job             = '0;
        o_job.kind        = KIND_CMD_PLAIN;
        o_job.op          = i_item.opcode;
        o_job.line_mask   = i_item.line_mask;
        o_job.member_mask = i_item.member_mask;
        o_job.step        = 5'd1;
        o_job.limit       = 9'd1;
        o_job.rows        = eff_r;
        unique case (i_item.req_type)
            REQ_ALL: begin
                o_job.limit = 9'(SWITCH_COUNT);
            end
            REQ_ONE: begin
                o_job.start = {1'b0, i_item.switch_index};
            end
            REQ_ROW, REQ_ROW_MEM: begin
                o_job.kind       = KIND_CMD_GRID;
                o_job.limit      = grid_size;
                o_job.use_member = (i_item.req_type == REQ_ROW_MEM);
            end
            REQ_COL, REQ_COL_MEM: begin
                o_job.kind       = KIND_CMD_GRID;
                o_job.limit      = grid_size;
                o_job.is_col     = 1'b1;
                o_job.use_member = (i_item.req_type == REQ_COL_MEM);
            end
            REQ_MASK: begin
                o_job.kind  = KIND_CMD_MASK;
                o_job.limit = 9'd64;
            end
            REQ_READ: begin
                if (i_item.read_scope == SCOPE_ALL) begin
                    o_job.kind = KIND_RD_ALL;
                end else if (i_item.read_scope == SCOPE_ROW
                             && {1'b0, i_item.line_index} < eff_r) begin
                    o_job.kind  = KIND_RD_LINE;
                    o_job.start = {5'd0, i_item.line_index};
                    o_job.step  = eff_r;
                    o_job.limit = {4'd0, eff_c};
                end else if (i_item.read_scope == SCOPE_COL
                             && {1'b0, i_item.line_index} < eff_c) begin
                    o_job.kind  = KIND_RD_LINE;
                    o_job.start = col_base;
                    o_job.limit = {4'd0, eff_r};
                end else begin
                    o_job.kind = KIND_RD_BAD;
                end
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/smhc_fifo.sv
`default_nettype none
module smhc_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire smhc_pkg::t_job i_job,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_valid,
    output smhc_pkg::t_job      o_job
);
    import smhc_pkg::*;

    t_job       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule
`default_nettype wire

FILE: rtl/smhc_back.sv
`default_nettype none
module smhc_back #(
    parameter int SWITCH_COUNT = 64
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_job_valid,
    input  wire smhc_pkg::t_job i_job,
    output logic                o_pop,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output smhc_pkg::t_out_item o_out_data
);
    import smhc_pkg::*;

    localparam int IW = (SWITCH_COUNT > 1) ? $clog2(SWITCH_COUNT) : 1;

    logic [SWITCH_COUNT-1:0] r_on;
    logic [SWITCH_COUNT-1:0] r_hold;
    logic                    r_busy;
    t_job                    r_job;
    logic [8:0]              r_s;
    logic [8:0]              r_n;
    logic [3:0]              r_r;
    logic [3:0]              r_c;
    logic                    r_range;
    logic                    r_refused;
    logic [63:0]             r_onb;
    logic [63:0]             r_hb;
    logic                    r_out_valid;
    t_out_item               r_out;

    logic          sw_ok;
    logic [IW-1:0] idx;
    logic          held;
    logic          sel;
    logic          is_cmd;
    logic          hit;
    logic          refuse;
    logic          do_write;
    logic          n_range;
    logic          n_refused;
    logic [63:0]   n_onb;
    logic [63:0]   n_hb;
    logic          last;
    logic          out_free;
    logic          step_en;
    logic          col_wrap;
    t_out_item     n_out;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_pop       = !r_busy && i_job_valid;
    assign last        = (9'(r_n + 9'd1) == r_job.limit);
    assign step_en     = r_busy && (!last || out_free);

    always_comb begin
        sw_ok  = (r_s < 9'(SWITCH_COUNT));
        idx    = r_s[IW-1:0];
        held   = sw_ok && r_hold[idx];
        is_cmd = (r_job.kind == KIND_CMD_PLAIN) || (r_job.kind == KIND_CMD_GRID)
                 || (r_job.kind == KIND_CMD_MASK);
        unique case (r_job.kind)
            KIND_CMD_PLAIN: sel = 1'b1;
            KIND_CMD_GRID: begin
                if (r_job.is_col) begin
                    sel = r_job.line_mask[r_c]
                          && (!r_job.use_member || r_job.member_mask[{2'd0, r_r}]);
                end else begin
                    sel = r_job.line_mask[r_r]
                          && (!r_job.use_member || r_job.member_mask[{2'd0, r_c}]);
                end
            end
            KIND_CMD_MASK: sel = r_job.member_mask[r_s[5:0]];
            default:       sel = 1'b0;
        endcase
        hit = is_cmd && sel && sw_ok;
        priority if (r_job.op[2:1] == 2'b11) begin
            refuse = 1'b0;
        end else if (r_job.op[2]) begin
            refuse = hit && !held;
        end else begin
            refuse = hit && held;
        end
        do_write  = hit && !refuse;
        n_range   = r_range || (is_cmd && sel && !sw_ok)
                    || (r_job.kind == KIND_RD_LINE && !sw_ok)
                    || (r_job.kind == KIND_RD_BAD);
        n_refused = r_refused || refuse;
        n_onb     = r_onb;
        n_hb      = r_hb;
        if (r_job.kind == KIND_RD_LINE && sw_ok) begin
            n_onb[r_n[5:0]] = r_on[idx];
            n_hb[r_n[5:0]]  = r_hold[idx];
        end
        col_wrap = ({1'b0, r_r} + 5'd1 == r_job.rows);
    end

    always_comb begin
        n_out             = '0;
        n_out.status_code = n_range ? ST_RANGE : (n_refused ? ST_REFUSED : ST_DONE);
        unique case (r_job.kind)
            KIND_RD_ALL: begin
                n_out.on_bits   = 64'(r_on);
                n_out.hold_bits = 64'(r_hold);
                n_out.bit_total = 7'(SWITCH_COUNT);
            end
            KIND_RD_LINE: begin
                n_out.on_bits   = n_onb;
                n_out.hold_bits = n_hb;
                n_out.bit_total = r_job.limit[6:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
            r_s   <= i_job.start;
            r_n   <= 9'd0;
            r_r   <= 4'd0;
            r_c   <= 4'd0;
            r_onb <= '0;
            r_hb  <= '0;
        end else if (step_en) begin
            r_s   <= r_s + {4'd0, r_job.step};
            r_n   <= r_n + 9'd1;
            r_onb <= n_onb;
            r_hb  <= n_hb;
            if (col_wrap) begin
                r_r <= 4'd0;
                r_c <= r_c + 4'd1;
            end else begin
                r_r <= r_r + 4'd1;
            end
        end
        if (step_en && last) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on        <= '0;
            r_hold      <= '0;
            r_busy      <= 1'b0;
            r_range     <= 1'b0;
            r_refused   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy    <= 1'b1;
                r_range   <= 1'b0;
                r_refused <= 1'b0;
            end else if (step_en) begin
                r_range   <= n_range;
                r_refused <= n_refused;
                if (do_write) begin
                    r_on[idx]   <= r_job.op[0];
                    r_hold[idx] <= !r_job.op[2] && r_job.op[1];
                end
                if (last) begin
                    r_busy <= 1'b0;
                end
            end
            if (step_en && last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

FILE: tb/tb_switch_matrix_hold_control.sv
`timescale 1ns / 100ps
module tb_switch_matrix_hold_control;
    import smhc_pkg::*;

    localparam int SWITCH_COUNT = 64;

    localparam logic [2:0] OP_OFF       = 3'd0;
    localparam logic [2:0] OP_ON        = 3'd1;
    localparam logic [2:0] OP_HOLD_OFF  = 3'd2;
    localparam logic [2:0] OP_HOLD_ON   = 3'd3;
    localparam logic [2:0] OP_REL_OFF   = 3'd4;
    localparam logic [2:0] OP_REL_ON    = 3'd5;
    localparam logic [2:0] OP_FORCE_OFF = 3'd6;
    localparam logic [2:0] OP_FORCE_ON  = 3'd7;

    localparam logic [1:0] SCOPE_BAD = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in_item i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out_item o_out_data;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDXW-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    t_in_item pending_cmds[$];
    t_out_item expected_status[$];

    logic [63:0] sw_on = '0;
    logic [63:0] sw_hold = '0;
    logic [4:0] rows_reg = 5'd8;
    logic [4:0] cols_reg = 5'd8;
    logic hit_range;
    logic hit_refused;

    logic in_taken = 1'b0;
    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    logic hold_off_req = 1'b0;
    logic hold_off_ack = 1'b0;
    int hold_off_left = 0;
    int err_cnt = 0;

    switch_matrix_hold_control #(
        .SWITCH_COUNT(SWITCH_COUNT)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in_data(i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic int eff_dim(logic [4:0] v);
        if (v == 5'd0) return 1;
        if (v > 5'd16) return 16;
        return int'(v);
    endfunction

    function automatic void apply_switch(logic [2:0] op, int sw);
        logic held;
        if (sw >= SWITCH_COUNT) begin
            hit_range = 1'b1;
            return;
        end
        held = sw_hold[sw];
        case (op)
            OP_OFF, OP_ON, OP_HOLD_OFF, OP_HOLD_ON: begin
                if (held) begin
                    hit_refused = 1'b1;
                    return;
                end
                if (op == OP_HOLD_OFF || op == OP_HOLD_ON) sw_hold[sw] = 1'b1;
            end
            OP_REL_OFF, OP_REL_ON: begin
                if (!held) begin
                    hit_refused = 1'b1;
                    return;
                end
                sw_hold[sw] = 1'b0;
            end
            default: begin
                sw_hold[sw] = 1'b0;
            end
        endcase
        sw_on[sw] = op[0];
    endfunction

    function automatic t_out_item switch_cmd_result(t_in_item it);
        t_out_item r;
        int nr;
        int nc;
        int base;
        int stride;
        int len;
        int sw;
        r = '0;
        hit_range = 1'b0;
        hit_refused = 1'b0;
        nr = eff_dim(rows_reg);
        nc = eff_dim(cols_reg);
        case (it.req_type)
            REQ_ALL: begin
                for (int a = 0; a < SWITCH_COUNT; a++) apply_switch(it.opcode, a);
            end
            REQ_ONE: begin
                apply_switch(it.opcode, int'(it.switch_index));
            end
            REQ_ROW, REQ_ROW_MEM: begin
                for (int a = 0; a < nr; a++) begin
                    if (it.line_mask[a]) begin
                        for (int b = 0; b < nc; b++) begin
                            if (it.req_type != REQ_ROW_MEM || it.member_mask[b])
                                apply_switch(it.opcode, a + b * nr);
                        end
                    end
                end
            end
            REQ_COL, REQ_COL_MEM: begin
                for (int a = 0; a < nc; a++) begin
                    if (it.line_mask[a]) begin
                        for (int b = 0; b < nr; b++) begin
                            if (it.req_type != REQ_COL_MEM || it.member_mask[b])
                                apply_switch(it.opcode, a * nr + b);
                        end
                    end
                end
            end
            REQ_MASK: begin
                for (int a = 0; a < 64; a++)
                    if (it.member_mask[a]) apply_switch(it.opcode, a);
            end
            default: begin
                base = 0;
                stride = 1;
                len = 0;
                if (it.read_scope == SCOPE_ALL) begin
                    len = SWITCH_COUNT;
                end else if (it.read_scope == SCOPE_ROW && int'(it.line_index) < nr) begin
                    base = int'(it.line_index);
                    stride = nr;
                    len = nc;
                end else if (it.read_scope == SCOPE_COL && int'(it.line_index) < nc) begin
                    base = int'(it.line_index) * nr;
                    len = nr;
                end else begin
                    hit_range = 1'b1;
                end
                for (int b = 0; b < len; b++) begin
                    sw = base + b * stride;
                    if (sw >= SWITCH_COUNT) begin
                        hit_range = 1'b1;
                    end else begin
                        r.on_bits[b] = sw_on[sw];
                        r.hold_bits[b] = sw_hold[sw];
                    end
                end
                r.bit_total = 7'(len);
            end
        endcase
        r.status_code = hit_range ? ST_RANGE : (hit_refused ? ST_REFUSED : ST_DONE);
        return r;
    endfunction

    function automatic t_in_item mk_cmd(logic [2:0] req, logic [2:0] op, logic [7:0] sw,
                                        logic [15:0] lm, logic [63:0] mm, logic [1:0] scope,
                                        logic [3:0] lidx);
        t_in_item it;
        it.req_type = req;
        it.opcode = op;
        it.switch_index = sw;
        it.line_mask = lm;
        it.member_mask = mm;
        it.read_scope = scope;
        it.line_index = lidx;
        return it;
    endfunction

    function automatic t_in_item rand_cmd();
        t_in_item it;
        int pick;
        pick = $urandom_range(99);
        if (pick < 5) it.req_type = REQ_ALL;
        else if (pick < 20) it.req_type = REQ_ONE;
        else if (pick < 30) it.req_type = REQ_ROW;
        else if (pick < 40) it.req_type = REQ_ROW_MEM;
        else if (pick < 50) it.req_type = REQ_COL;
        else if (pick < 60) it.req_type = REQ_COL_MEM;
        else if (pick < 72) it.req_type = REQ_MASK;
        else it.req_type = REQ_READ;
        it.opcode = 3'($urandom_range(7));
        if ($urandom_range(3) != 0) it.switch_index = 8'($urandom_range(SWITCH_COUNT - 1));
        else it.switch_index = 8'($urandom_range(255));
        case ($urandom_range(2))
            0: it.line_mask = 16'($urandom);
            1: it.line_mask = 16'(1) << $urandom_range(15);
            default: it.line_mask = 16'($urandom) & 16'($urandom);
        endcase
        case ($urandom_range(3))
            0: it.member_mask = {$urandom, $urandom} & {$urandom, $urandom};
            1: it.member_mask = 64'(1) << $urandom_range(63);
            default: it.member_mask = {$urandom, $urandom};
        endcase
        if ($urandom_range(9) == 0) it.read_scope = SCOPE_BAD;
        else it.read_scope = 2'($urandom_range(2));
        it.line_index = 4'($urandom_range(15));
        return it;
    endfunction

    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (pending_cmds.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                i_in_data <= pending_cmds.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_off_req != hold_off_ack) begin
            hold_off_ack <= hold_off_req;
            hold_off_left <= 400;
            i_out_ready <= 1'b0;
        end else if (hold_off_left != 0) begin
            hold_off_left <= hold_off_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        in_taken <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_status.size() == 0) begin
                    $error("Unexpected result transfer: status_code %0d", o_out_data.status_code);
                    err_cnt++;
                end else begin
                    want = expected_status.pop_front();
                    if (o_out_data.status_code !== want.status_code) begin
                        $error("status_code: expected %0d, got %0d",
                               want.status_code, o_out_data.status_code);
                        err_cnt++;
                    end
                    if (o_out_data.on_bits !== want.on_bits) begin
                        $error("on_bits: expected %h, got %h", want.on_bits, o_out_data.on_bits);
                        err_cnt++;
                    end
                    if (o_out_data.hold_bits !== want.hold_bits) begin
                        $error("hold_bits: expected %h, got %h",
                               want.hold_bits, o_out_data.hold_bits);
                        err_cnt++;
                    end
                    if (o_out_data.bit_total !== want.bit_total) begin
                        $error("bit_total: expected %0d, got %0d",
                               want.bit_total, o_out_data.bit_total);
                        err_cnt++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) expected_status.push_back(switch_cmd_result(i_in_data));
        end
    end

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || i_in_valid || expected_status.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDXW-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_ROWS) rows_reg = val;
        else cols_reg = val;
    endtask

    task automatic run_phase(input logic [4:0] nr, input logic [4:0] nc,
                             input int gap_pct, input int stall_pct, input int n);
        wait_drained();
        write_reg(CFG_ROWS, nr);
        write_reg(CFG_COLS, nc);
        @(posedge i_clk);
        send_gap_pct = gap_pct;
        recv_stall_pct = stall_pct;
        for (int k = 0; k < n; k++) pending_cmds.push_back(rand_cmd());
    endtask

    initial begin
        logic [4:0] set_rows[10];
        logic [4:0] set_cols[10];
        int gap_set[4];
        int stall_set[4];
        logic [4:0] nr;
        logic [4:0] nc;

        set_rows = '{5'd16, 5'd0, 5'd1, 5'd16, 5'd31, 5'd4, 5'd16, 5'd8, 5'd3, 5'd7};
        set_cols = '{5'd16, 5'd0, 5'd16, 5'd1, 5'd17, 5'd16, 5'd4, 5'd8, 5'd5, 5'd9};
        gap_set = '{0, 56, 0, 22};
        stall_set = '{0, 0, 56, 22};

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        pending_cmds.push_back(mk_cmd(REQ_READ, OP_ON, 8'd0, '0, '0, SCOPE_ALL, 4'd0));
        pending_cmds.push_back(mk_cmd(REQ_ONE, OP_ON, 8'd0, '0, '0, SCOPE_ALL, 4'd0));
        pending_cmds.push_back(mk_cmd(REQ_ONE, OP_HOLD_ON, 8'd63, '0, '0, SCOPE_ALL, 4'd0));
        pending_cmds.push_back(mk_cmd(REQ_ONE, OP_OFF, 8'd63, '0, '0, SCOPE_ALL, 4'd0));
        pending_cmds.push_back(mk_cmd(REQ_ONE, OP_REL_OFF, 8'd0, '0, '0, SCOPE_ALL, 4'd0));
        pending_cmds.push_back(mk_cmd(REQ_ONE, OP_REL_OFF, 8'd63, '0, '0, SCOPE_ALL, 4'd0));
        pending_cmds.push_back(mk_cmd(REQ_ONE, OP_ON, 8'd255, '0, '0, SCOPE_ALL, 4'd0));
        pending_cmds.push_back(mk_cmd(REQ_ONE, OP_HOLD_OFF, 8'd64, '0, '0, SCOPE_ALL, 4'd0));
        pending_cmds.push_back(mk_cmd(REQ_ALL, OP_FORCE_ON, 8'd0, '0, '0, SCOPE_ALL, 4'd0));
        pending_cmds.push_back(mk_cmd(REQ_ROW, OP_HOLD_OFF, 8'd0, 16'hFFFF, '0, SCOPE_ALL,
                                      4'd0));
        pending_cmds.push_back(mk_cmd(REQ_ROW_MEM, OP_ON, 8'd0, 16'h0001, '1, SCOPE_ALL,
                                      4'd0));
        pending_cmds.push_back(mk_cmd(REQ_COL, OP_REL_ON, 8'd0, 16'h8081, '0, SCOPE_ALL,
                                      4'd0));
        pending_cmds.push_back(mk_cmd(REQ_COL_MEM, OP_FORCE_OFF, 8'd0, 16'hFFFF,
                                      64'hFFFF_FFFF_FFFF_FF0A, SCOPE_ALL, 4'd0));
        pending_cmds.push_back(mk_cmd(REQ_MASK, OP_HOLD_ON, 8'd0, '0, 64'h8000_0000_F0F0_0001,
                                      SCOPE_ALL, 4'd0));
        pending_cmds.push_back(mk_cmd(REQ_MASK, OP_ON, 8'd0, '0, '0, SCOPE_ALL, 4'd0));
        pending_cmds.push_back(mk_cmd(REQ_MASK, OP_REL_ON, 8'd0, '0, '1, SCOPE_ALL, 4'd0));
        pending_cmds.push_back(mk_cmd(REQ_READ, OP_OFF, 8'd0, '0, '0, SCOPE_ROW, 4'd0));
        pending_cmds.push_back(mk_cmd(REQ_READ, OP_OFF, 8'd0, '0, '0, SCOPE_COL, 4'd7));
        pending_cmds.push_back(mk_cmd(REQ_READ, OP_OFF, 8'd0, '0, '0, SCOPE_ROW, 4'd8));
        pending_cmds.push_back(mk_cmd(REQ_READ, OP_OFF, 8'd0, '0, '0, SCOPE_COL, 4'd15));
        pending_cmds.push_back(mk_cmd(REQ_READ, OP_FORCE_ON, 8'd0, '0, '0, SCOPE_BAD, 4'd0));
        pending_cmds.push_back(mk_cmd(REQ_ONE, OP_FORCE_OFF, 8'd5, '0, '0, SCOPE_ALL, 4'd0));
        pending_cmds.push_back(mk_cmd(REQ_READ, OP_FORCE_ON, 8'd0, '0, '0, SCOPE_ALL, 4'd0));

        for (int p = 0; p < 12; p++) begin
            if (p < 10) begin
                nr = set_rows[p];
                nc = set_cols[p];
            end else begin
                nr = 5'($urandom_range(31));
                nc = 5'($urandom_range(31));
            end
            run_phase(nr, nc, gap_set[p % 4], stall_set[p % 4], 35);
        end

        // The output side holds off while commands keep arriving, so the job queue fills.
        wait_drained();
        write_reg(CFG_ROWS, 5'd8);
        write_reg(CFG_COLS, 5'd8);
        @(posedge i_clk);
        send_gap_pct = 0;
        recv_stall_pct = 0;
        hold_off_req = ~hold_off_req;
        for (int k = 0; k < 40; k++) pending_cmds.push_back(rand_cmd());

        while (pending_cmds.size() != 0 || i_in_valid || expected_status.size() != 0)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);

        if (err_cnt == 0 && expected_status.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: switch_matrix_hold_control.f
rtl/smhc_pkg.sv
rtl/smhc_front.sv
rtl/smhc_fifo.sv
rtl/smhc_back.sv
rtl/switch_matrix_hold_control.sv
tb/tb_switch_matrix_hold_control.sv
